>>> hdl/key_fade_table_unit_macros.svh
// ----------------------------------------------------------------------------
// key_fade_table_unit_macros.svh
// Assertion macros for the key fade table RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_FADE_TABLE_UNIT_MACROS_SVH
`define KEY_FADE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clk edge out of reset
`define KFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge out of reset
`define KFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// Types, codes and sizes shared by the key fade table modules.
// ----------------------------------------------------------------------------
package kft_pkg;

  // Table sizing
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int CODE_W   = 16;
  localparam int FRAMES_W = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_SNAPSHOT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_EN     = 1'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] key_code;
  } kft_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CODE_W-1:0]   entry_code;
    logic [FRAMES_W-1:0] frames_left;
    logic                held;
    logic                empty_res;
    logic                last;
  } kft_out_t;

  // One table slot as stored in the memory
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [FRAMES_W-1:0] frames;
    logic                held;
  } kft_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;    // capture the accepted event
    logic scan_clr;    // restart the slot walk
    logic scan_run;    // advance the slot walk
    logic find;        // look for the event key
    logic commit;      // store the key event and report it
    logic age;         // age and compact the walked slots
    logic fill_load;   // take the compacted count as the new fill
    logic report;      // report the walked slots
    logic empty_emit;  // report an empty table
  } kft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             match;
    logic             done;
    logic             fill_zero;
    logic             anim_en;
    logic [CNT_W-1:0] fill_cnt;
  } kft_stat_t;

endpackage

>>> hdl/key_fade_table_unit.sv
// ----------------------------------------------------------------------------
// key_fade_table_unit
// Ordered table of lit keys for a keyboard backlight fade.
// ----------------------------------------------------------------------------
// Use: raise start with in_data while busy is low to transfer one event
// (press, release or frame tick). The block then works on that event alone
// and raises busy until it has finished; an unused kind is dropped at once.
// Results leave on out_data, each marked by out_valid for one cycle; the
// final result of an event has last set. The receiver cannot stall.
// The slots sit in one memory with a single write port and a registered
// read port, walked one slot a cycle. A press or release walks the table
// until a hit or the end and then gives its single result. A tick with
// ageing walks the table twice, once to age and compact it and once to
// report it (only the report walk without ageing); reports come one a cycle.
// Configuration writes on cfg_* take effect at once; write only while idle.
// Reset (synchronous, rst_n low) empties the table and loads fade_frames
// with 10 and animation_enable with 1. Memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "key_fade_table_unit_macros.svh"

module key_fade_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  kft_pkg::kft_in_t              in_data,
  output logic                          out_valid,
  output kft_pkg::kft_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [kft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kft_pkg::CFG_W-1:0]     cfg_wdata
);
  import kft_pkg::*;

  kft_cmd_t  cmd;
  kft_stat_t st;

  // Sequencer
  kft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table storage and result path
  kft_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `KFT_ASSERT_NOW(a_result_while_busy, out_valid, $past(busy), "result outside an event")
  `KFT_ASSERT_NEXT(a_event_goes_busy, start && !busy && (in_data.kind != KIND_UNUSED), busy, "event transfer did not start work")
  `KFT_ASSERT_NEXT(a_report_continues, out_valid && !out_data.last, out_valid, "report sequence broken before last")
  `KFT_ASSERT_NOW(a_fill_in_range, 1'b1, st.fill_cnt <= CNT_W'(CAPACITY), "fill count beyond capacity")

endmodule

>>> hdl/kft_datapath.sv
// ----------------------------------------------------------------------------
// kft_datapath
// Slot memory, fill count, walk counters, configuration and result register.
// ----------------------------------------------------------------------------
module kft_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kft_pkg::kft_in_t                in_data,
  input  logic                            cfg_we,
  input  logic [kft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kft_pkg::CFG_W-1:0]       cfg_wdata,
  input  kft_pkg::kft_cmd_t               cmd,
  output kft_pkg::kft_stat_t              st,
  output logic                            out_valid,
  output kft_pkg::kft_out_t               out_data
);
  import kft_pkg::*;

  kft_entry_t          mem [CAPACITY];
  kft_entry_t          rdata_r;

  logic [FRAMES_W-1:0] fade_r;
  logic                anim_r;
  logic [1:0]          kind_r;
  logic [CODE_W-1:0]   code_r;

  logic [CNT_W-1:0]    fill_r,     fill_nxt;
  logic [CNT_W-1:0]    scan_idx_r;
  logic [CNT_W-1:0]    wr_idx_r;
  logic [IDX_W-1:0]    pend_idx_r;
  logic                pend_vld_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;

  logic                out_valid_r, out_valid_nxt;
  kft_out_t            out_data_r,  out_data_nxt;

  logic                issue;
  logic                match;
  logic                pend_last;
  logic                keep;
  logic                room;
  logic                is_press;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  kft_entry_t          mem_wdata;

  assign issue     = cmd.scan_run && (scan_idx_r < fill_r);
  assign match     = pend_vld_r && (rdata_r.code == code_r);
  assign pend_last = (CNT_W'(pend_idx_r) + CNT_W'(1)) == fill_r;
  assign keep      = rdata_r.held || (rdata_r.frames > FRAMES_W'(1));
  assign room      = fill_r < CNT_W'(CAPACITY);
  assign is_press  = kind_r == KIND_PRESS;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= FRAMES_W'(10);
      anim_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_FRAMES: fade_r <= cfg_wdata[FRAMES_W-1:0];
        CFG_ANIM_EN:     anim_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_data.kind;
      code_r <= in_data.key_code;
    end
  end

  // Slot walk: read issued one cycle, data seen the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      wr_idx_r   <= '0;
      pend_vld_r <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_idx_r <= '0;
      wr_idx_r   <= '0;
      pend_vld_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      pend_vld_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (cmd.age && pend_vld_r && keep) begin
        wr_idx_r <= wr_idx_r + CNT_W'(1);
      end
      if (cmd.find && match) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.find && match) begin
      hit_idx_r <= pend_idx_r;
    end
  end

  // Memory write port: compaction writes or key event store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_r[IDX_W-1:0];
    mem_wdata = rdata_r;
    if (cmd.age) begin
      mem_we           = pend_vld_r && keep;
      mem_wdata.frames = rdata_r.held ? rdata_r.frames : rdata_r.frames - FRAMES_W'(1);
    end else if (cmd.commit) begin
      mem_we           = hit_r || room;
      mem_waddr        = hit_r ? hit_idx_r : fill_r[IDX_W-1:0];
      mem_wdata.code   = code_r;
      mem_wdata.frames = is_press ? '0 : fade_r;
      mem_wdata.held   = is_press;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[scan_idx_r[IDX_W-1:0]];
  end

  // Fill count
  always_comb begin
    fill_nxt = fill_r;
    priority if (cmd.fill_load) begin
      fill_nxt = wr_idx_r;
    end else if (cmd.commit && !hit_r && room) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    priority if (cmd.commit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.entry_code  = code_r;
      out_data_nxt.empty_res   = 1'b0;
      out_data_nxt.last        = 1'b1;
      if (hit_r || room) begin
        out_data_nxt.status      = hit_r ? ST_UPDATED : ST_INSERTED;
        out_data_nxt.frames_left = is_press ? '0 : fade_r;
        out_data_nxt.held        = is_press;
      end else begin
        out_data_nxt.status      = ST_FULL;
        out_data_nxt.frames_left = '0;
        out_data_nxt.held        = 1'b0;
      end
    end else if (cmd.empty_emit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = ST_SNAPSHOT;
      out_data_nxt.entry_code  = '0;
      out_data_nxt.frames_left = '0;
      out_data_nxt.held        = 1'b0;
      out_data_nxt.empty_res   = 1'b1;
      out_data_nxt.last        = 1'b1;
    end else if (cmd.report && pend_vld_r) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = ST_SNAPSHOT;
      out_data_nxt.entry_code  = rdata_r.code;
      out_data_nxt.frames_left = rdata_r.held ? '0 : rdata_r.frames;
      out_data_nxt.held        = rdata_r.held;
      out_data_nxt.empty_res   = 1'b0;
      out_data_nxt.last        = pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  assign st.match     = match;
  assign st.done      = !pend_vld_r && (scan_idx_r >= fill_r);
  assign st.fill_zero = fill_r == '0;
  assign st.anim_en   = anim_r;
  assign st.fill_cnt  = fill_r;

endmodule

>>> hdl/kft_ctrl.sv
// ----------------------------------------------------------------------------
// kft_ctrl
// Sequencer: search and store for key events, age (when animation is on) then report for ticks.
// ----------------------------------------------------------------------------
module kft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         kind,
  input  kft_pkg::kft_stat_t st,
  output kft_pkg::kft_cmd_t  cmd,
  output logic               busy
);
  import kft_pkg::*;

  localparam logic [2:0] S_IDLE         = 3'd0;
  localparam logic [2:0] S_FIND         = 3'd1;
  localparam logic [2:0] S_COMMIT       = 3'd2;
  localparam logic [2:0] S_AGE          = 3'd3;
  localparam logic [2:0] S_REPORT_START = 3'd4;
  localparam logic [2:0] S_REPORT       = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          cmd.scan_clr = 1'b1;
          unique case (kind)
            KIND_PRESS, KIND_RELEASE: state_nxt = S_FIND;
            KIND_TICK:   state_nxt = st.anim_en ? S_AGE : S_REPORT_START;
            KIND_UNUSED: state_nxt = S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        cmd.scan_run = 1'b1;
        cmd.find     = 1'b1;
        if (st.match || st.done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_AGE: begin
        cmd.scan_run = 1'b1;
        cmd.age      = 1'b1;
        if (st.done) begin
          cmd.fill_load = 1'b1;
          state_nxt     = S_REPORT_START;
        end
      end
      S_REPORT_START: begin
        cmd.scan_clr = 1'b1;
        if (st.fill_zero) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        cmd.scan_run = 1'b1;
        cmd.report   = 1'b1;
        if (st.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key fade table. A short directed table
// (empty tick, code extremes, hits, misses, unused kind) is followed by
// random phases under several fade / animation settings and sender gap
// rates. Every accepted event is run through a local copy of the table,
// and each output transfer is compared field by field with the oldest
// awaited report.
// ----------------------------------------------------------------------------
module tb_top;
  import kft_pkg::*;

  localparam int DRAIN_CYCLES = 150;      // a bit over the worst item latency
  localparam int TIMEOUT_NS   = 4000000;

  // Random stimulus flavours
  typedef enum int {MIX_SMALL, FILL_UP, FADE_OUT} mix_t;

  // Directed stimulus row: event plus optional hand-written expectation
  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] code;
    logic              typed;
    kft_out_t          want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  kft_in_t              in_data;
  logic                 out_valid;
  kft_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Local copy of the table and its settings
  kft_entry_t           lit_keys [CAPACITY];
  int                   lit_count;
  logic [FRAMES_W-1:0]  fade_setting;
  logic                 anim_setting;

  kft_out_t             event_reports[$];   // reports of the latest event
  kft_out_t             awaited_reports[$]; // reports still to come out
  stim_row_t            dir_rows[$];
  int                   err_count;

  key_fade_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic kft_out_t mk_report(logic [1:0] st, logic [CODE_W-1:0] code,
                                         logic [FRAMES_W-1:0] fr, logic h,
                                         logic e, logic l);
    kft_out_t r;
    r.status      = st;
    r.entry_code  = code;
    r.frames_left = fr;
    r.held        = h;
    r.empty_res   = e;
    r.last        = l;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] kind, logic [CODE_W-1:0] code,
                                       logic typed, kft_out_t want);
    stim_row_t row;
    row.kind  = kind;
    row.code  = code;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Table behaviour: updates the local copy, leaves reports in event_reports
  function automatic void model_event(kft_in_t ev);
    int         i;
    int         hit;
    int         wr;
    logic       is_press;
    kft_entry_t e;
    kft_out_t   r;
    event_reports.delete();
    is_press = (ev.kind == KIND_PRESS);
    case (ev.kind)
      KIND_PRESS, KIND_RELEASE: begin
        hit = -1;
        for (i = 0; i < lit_count; i++)
          if (hit < 0 && lit_keys[i].code == ev.key_code) hit = i;
        if (hit < 0 && lit_count == CAPACITY) begin
          // no room: key dropped
          event_reports.push_back(mk_report(ST_FULL, ev.key_code, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          r = mk_report(ST_UPDATED, ev.key_code, is_press ? '0 : fade_setting,
                        is_press, 1'b0, 1'b1);
          if (hit < 0) begin
            hit = lit_count;
            lit_count++;
            r.status = ST_INSERTED;
          end
          lit_keys[hit].code   = ev.key_code;
          lit_keys[hit].frames = r.frames_left;
          lit_keys[hit].held   = is_press;
          event_reports.push_back(r);
        end
      end
      KIND_TICK: begin
        // age and compact, keeping order
        if (anim_setting) begin
          wr = 0;
          for (i = 0; i < lit_count; i++) begin
            e = lit_keys[i];
            if (e.held || e.frames > 1) begin
              if (!e.held) e.frames = e.frames - 1'b1;
              lit_keys[wr] = e;
              wr++;
            end
          end
          lit_count = wr;
        end
        if (lit_count == 0)
          event_reports.push_back(mk_report(ST_SNAPSHOT, '0, '0, 1'b0, 1'b1, 1'b1));
        for (i = 0; i < lit_count; i++)
          event_reports.push_back(mk_report(ST_SNAPSHOT, lit_keys[i].code,
                                            lit_keys[i].held ? '0 : lit_keys[i].frames,
                                            lit_keys[i].held, 1'b0,
                                            i == lit_count - 1));
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Output monitor: every transfer against the oldest awaited report
  always @(posedge clk) begin
    kft_out_t want;
    if (rst_n && out_valid) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result: status %0h entry_code %0h", out_data.status,
               out_data.entry_code);
        err_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("entry_code", want.entry_code, out_data.entry_code);
        check_field("frames_left", want.frames_left, out_data.frames_left);
        check_field("held", want.held, out_data.held);
        check_field("empty_res", want.empty_res, out_data.empty_res);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transfer
  task automatic send_event(input kft_in_t ev, input int idle_pct, input logic typed,
                            input kft_out_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (busy);
    model_event(ev);
    if (typed) awaited_reports.push_back(want);
    else while (event_reports.size() > 0) awaited_reports.push_back(event_reports.pop_front());
    @(negedge clk);
  endtask

  // Hold off until every awaited report is out and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (awaited_reports.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_registers(input logic [FRAMES_W-1:0] fade, input logic anim);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FADE_FRAMES;
    cfg_wdata <= fade;
    fade_setting = fade;
    @(negedge clk);
    // upper bits of the enable write are don't-care
    cfg_index <= CFG_ANIM_EN;
    cfg_wdata <= {7'($urandom_range(127)), anim};
    anim_setting = anim;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input int idle_pct, input mix_t mix);
    int      n;
    int      roll;
    kft_in_t ev;
    for (n = 0; n < count; n++) begin
      roll        = $urandom_range(99);
      ev.key_code = CODE_W'($urandom);
      case (mix)
        MIX_SMALL: begin
          // a few codes, so hits, re-presses and re-releases are common
          ev.kind = roll < 35 ? KIND_PRESS : roll < 65 ? KIND_RELEASE :
                    roll < 95 ? KIND_TICK : KIND_UNUSED;
          if ($urandom_range(9) != 0) ev.key_code = CODE_W'($urandom_range(7));
        end
        FILL_UP: begin
          // mostly fresh codes, to run the table into the full case
          ev.kind = roll < 45 ? KIND_PRESS : roll < 90 ? KIND_RELEASE : KIND_TICK;
        end
        default: begin
          // release and tick keys that are lit, so the table empties out
          ev.kind = roll < 55 ? KIND_RELEASE : roll < 80 ? KIND_TICK :
                    roll < 97 ? KIND_PRESS : KIND_UNUSED;
          if (roll < 92 && lit_count > 0)
            ev.key_code = lit_keys[$urandom_range(lit_count - 1)].code;
        end
      endcase
      send_event(ev, idle_pct, 1'b0, '0);
    end
  endtask

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

  // Main stimulus
  initial begin
    kft_in_t ev;
    err_count    = 0;
    lit_count    = 0;
    fade_setting = 8'd10;
    anim_setting = 1'b1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;

    // Directed rows, reset settings (fade 10, animation on)
    dir_rows.push_back(mk_row(KIND_TICK, 16'h0000, 1'b1,
                              mk_report(ST_SNAPSHOT, '0, '0, 1'b0, 1'b1, 1'b1)));
    dir_rows.push_back(mk_row(KIND_PRESS, 16'h0000, 1'b1,
                              mk_report(ST_INSERTED, 16'h0000, '0, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_PRESS, 16'hFFFF, 1'b1,
                              mk_report(ST_INSERTED, 16'hFFFF, '0, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_RELEASE, 16'h0000, 1'b1,
                              mk_report(ST_UPDATED, 16'h0000, 8'd10, 1'b0, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_RELEASE, 16'h5A5A, 1'b1,
                              mk_report(ST_INSERTED, 16'h5A5A, 8'd10, 1'b0, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_PRESS, 16'hFFFF, 1'b1,
                              mk_report(ST_UPDATED, 16'hFFFF, '0, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_UNUSED, 16'h1234, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_TICK, 16'hFFFF, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_PRESS, 16'h5A5A, 1'b1,
                              mk_report(ST_UPDATED, 16'h5A5A, '0, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_RELEASE, 16'hFFFF, 1'b1,
                              mk_report(ST_UPDATED, 16'hFFFF, 8'd10, 1'b0, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_TICK, 16'h0000, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_UNUSED, 16'hFFFF, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_RELEASE, 16'hA5A5, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_TICK, 16'h0000, 1'b0, '0));

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      ev.kind     = dir_rows[k].kind;
      ev.key_code = dir_rows[k].code;
      send_event(ev, 0, dir_rows[k].typed, dir_rows[k].want);
    end

    // Shortest fade, back to back
    set_registers(8'd1, 1'b1);
    run_random(20, 0, MIX_SMALL);
    // Longest fade, no ageing: table fills and drops keys
    set_registers(8'd255, 1'b0);
    run_random(75, 78, FILL_UP);
    // Zero fade behaves as one: released keys go at the next tick
    set_registers(8'd0, 1'b1);
    run_random(16, 36, FADE_OUT);
    // Mid fade, no gaps
    set_registers(8'd128, 1'b1);
    run_random(10, 0, FADE_OUT);

    drain();
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
